[rtl/core/idfc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// idfc_pkg - shared types and constants of the identifier field classifier
// Sizes, opcodes, class codes, beat structs and small character helpers.
// ----------------------------------------------------------------------------
package idfc_pkg;

  localparam int MAX_FIELDS     = 16;
  localparam int MAX_FIELD_LEN  = 32;
  localparam int MAX_SEPARATORS = 32;

  localparam int FLD_W     = $clog2(MAX_FIELDS + 1);
  localparam int IDX_W     = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int LEN_W     = $clog2(MAX_FIELD_LEN + 1);
  localparam int SEP_W     = $clog2(MAX_SEPARATORS + 1);
  localparam int SIDX_W    = (MAX_SEPARATORS > 1) ? $clog2(MAX_SEPARATORS) : 1;
  localparam int REF_DEPTH = MAX_FIELDS * MAX_FIELD_LEN;
  localparam int REF_AW    = $clog2(REF_DEPTH);
  localparam int VAL_W     = 31;

  localparam logic [VAL_W-1:0] NUM_LIMIT = {VAL_W{1'b1}};

  // opcodes
  localparam logic [1:0] OP_CHAR   = 2'd0;
  localparam logic [1:0] OP_EOL    = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  // field classes
  localparam logic [1:0] CLS_SAME  = 2'd0;
  localparam logic [1:0] CLS_INCR  = 2'd1;
  localparam logic [1:0] CLS_IRREG = 2'd2;

  // characters
  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7a;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5a;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] field_index;
    logic [1:0] field_class;
    logic [4:0] field_count;
    logic       last;
    logic       error;
  } out_beat_t;

  // state handed to the report sequencer when a report is accepted
  typedef struct packed {
    logic [2*MAX_FIELDS-1:0] classes;
    logic [FLD_W-1:0]        total;
    logic                    error;
  } rpt_snap_t;

  typedef struct packed {
    logic             ovf;
    logic [VAL_W-1:0] val;
  } num_t;

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return c inside {CH_AT, [CH_0:CH_9], [CH_LA:CH_LZ], [CH_UA:CH_UZ]};
  endfunction

  // value*10 + d, saturating at NUM_LIMIT
  function automatic num_t add_digit(logic [VAL_W-1:0] v, logic [3:0] d);
    logic [VAL_W+3:0] ext;
    logic [VAL_W+3:0] prod;
    num_t             r;
    ext  = {4'b0, v};
    prod = (ext << 3) + (ext << 1) + {{VAL_W{1'b0}}, d};
    if (prod > {4'b0, NUM_LIMIT}) begin
      r.ovf = 1'b1;
      r.val = NUM_LIMIT;
    end else begin
      r.ovf = 1'b0;
      r.val = prod[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [REF_AW-1:0] ref_addr(logic [FLD_W-1:0] f, logic [LEN_W-1:0] l);
    return REF_AW'(int'(f) * MAX_FIELD_LEN + int'(l));
  endfunction

endpackage
`default_nettype wire

[rtl/core/idfc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// idfc_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module idfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/idfc_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// idfc_scan - template capture and per-token field classing
// Consumes one byte or end-of-line beat per cycle and keeps all field state.
// ----------------------------------------------------------------------------
module idfc_scan (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 acc,
  input  wire idfc_pkg::in_beat_t   beat,
  output idfc_pkg::rpt_snap_t       snap
);
  import idfc_pkg::*;

  logic                done_r, done_nxt;
  logic [SEP_W-1:0]    sep_cnt_r, sep_cnt_nxt;
  logic [FLD_W-1:0]    ft_r, ft_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [FLD_W-1:0]    fld_r, fld_nxt;
  logic [SEP_W-1:0]    sep_r, sep_nxt;
  logic                mism_r, mism_nxt;
  logic                num_r, num_nxt;
  logic                ne_r, ne_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic                err_r, err_nxt;

  logic [7:0]          sep_list_r [MAX_SEPARATORS];
  logic [LEN_W-1:0]    ref_len_r  [MAX_FIELDS];
  logic [VAL_W-1:0]    last_val_r [MAX_FIELDS];
  logic [1:0]          cls_r      [MAX_FIELDS];

  logic                sep_we, tpl_we, cls_we, lv_we, ram_we;
  logic [IDX_W-1:0]    lv_idx;
  logic                tpl_close, dat_close, eol;
  logic [1:0]          dc_cls;
  logic                dc_incr;

  logic [7:0]          c;
  logic [IDX_W-1:0]    fi;
  logic                f_ok;
  logic [LEN_W-1:0]    ref_len_f;
  logic                sep_hit;
  logic                same;
  logic [7:0]          rdata;
  num_t                addn;

  assign c         = beat.char_code;
  assign fi        = fld_r[IDX_W-1:0];
  assign f_ok      = fld_r < ft_r;
  assign ref_len_f = ref_len_r[fi];
  assign sep_hit   = (sep_r < sep_cnt_r) && (c == sep_list_r[sep_r[SIDX_W-1:0]]);
  assign addn      = add_digit(val_r, c[3:0] - CH_0[3:0]);
  assign same      = !mism_r && (len_r == ref_len_f);

  // class update when a data token closes
  always_comb begin
    dc_incr = 1'b0;
    dc_cls  = cls_r[fi];
    if (!same) begin
      if (num_r && cls_r[fi] != CLS_IRREG && val_r >= last_val_r[fi]) begin
        dc_cls  = CLS_INCR;
        dc_incr = 1'b1;
      end else begin
        dc_cls = CLS_IRREG;
      end
    end else if (cls_r[fi] == CLS_INCR) begin
      dc_cls = CLS_IRREG;
    end
  end

  always_comb begin
    done_nxt    = done_r;
    sep_cnt_nxt = sep_cnt_r;
    ft_nxt      = ft_r;
    len_nxt     = len_r;
    fld_nxt     = fld_r;
    sep_nxt     = sep_r;
    mism_nxt    = mism_r;
    num_nxt     = num_r;
    ne_nxt      = ne_r;
    val_nxt     = val_r;
    err_nxt     = err_r;
    sep_we      = 1'b0;
    tpl_we      = 1'b0;
    cls_we      = 1'b0;
    lv_we       = 1'b0;
    ram_we      = 1'b0;
    lv_idx      = ft_r[IDX_W-1:0];
    tpl_close   = 1'b0;
    dat_close   = 1'b0;
    eol         = 1'b0;

    if (acc) begin
      case (beat.opcode)
        OP_CHAR: begin
          if (!done_r) begin
            if (!is_word(c)) begin
              if (sep_cnt_r < SEP_W'(MAX_SEPARATORS)) begin
                sep_we      = 1'b1;
                sep_cnt_nxt = sep_cnt_r + 1'b1;
              end else begin
                err_nxt = 1'b1;
              end
              tpl_close = 1'b1;
            end else begin
              ne_nxt = 1'b1;
              if (ft_r >= FLD_W'(MAX_FIELDS) || len_r >= LEN_W'(MAX_FIELD_LEN)) begin
                err_nxt = 1'b1;
              end else begin
                ram_we  = 1'b1;
                len_nxt = len_r + 1'b1;
                if (num_r && is_digit(c)) begin
                  val_nxt = addn.val;
                  err_nxt = err_r | addn.ovf;
                end else begin
                  num_nxt = 1'b0;
                end
              end
            end
          end else if (sep_hit) begin
            dat_close = 1'b1;
            sep_nxt   = sep_r + 1'b1;
          end else begin
            ne_nxt = 1'b1;
            if (!(f_ok && len_r < ref_len_f && rdata == c)) begin
              mism_nxt = 1'b1;
            end
            if (len_r < LEN_W'(MAX_FIELD_LEN)) begin
              len_nxt = len_r + 1'b1;
            end
            if (is_digit(c)) begin
              val_nxt = addn.val;
              err_nxt = err_r | addn.ovf;
            end else begin
              num_nxt = 1'b0;
            end
          end
        end
        OP_EOL: begin
          eol = 1'b1;
          if (!done_r) begin
            tpl_close = 1'b1;
            done_nxt  = 1'b1;
          end else begin
            dat_close = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (tpl_close && ne_r && ft_r < FLD_W'(MAX_FIELDS)) begin
      tpl_we = 1'b1;
      lv_we  = 1'b1;
      ft_nxt = ft_r + 1'b1;
    end

    if (dat_close && ne_r) begin
      if (!f_ok) begin
        err_nxt = 1'b1;
      end else begin
        cls_we  = 1'b1;
        lv_we   = dc_incr;
        lv_idx  = fi;
        fld_nxt = fld_r + 1'b1;
      end
    end

    if (tpl_close || dat_close) begin
      len_nxt  = '0;
      mism_nxt = 1'b0;
      num_nxt  = 1'b1;
      ne_nxt   = 1'b0;
      val_nxt  = '0;
    end

    if (eol) begin
      fld_nxt = '0;
      sep_nxt = '0;
    end
  end

  // reference bytes; the read address follows the next cursor so the
  // byte for the next data character is ready when it arrives
  idfc_ram #(
    .WIDTH (8),
    .DEPTH (REF_DEPTH)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ref_addr(ft_r, len_r)),
    .wdata (c),
    .raddr (ref_addr(fld_nxt, len_nxt)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r    <= 1'b0;
      sep_cnt_r <= '0;
      ft_r      <= '0;
      len_r     <= '0;
      fld_r     <= '0;
      sep_r     <= '0;
      mism_r    <= 1'b0;
      num_r     <= 1'b1;
      ne_r      <= 1'b0;
      val_r     <= '0;
      err_r     <= 1'b0;
      for (int i = 0; i < MAX_FIELDS; i++) begin
        cls_r[i] <= CLS_SAME;
      end
    end else begin
      done_r    <= done_nxt;
      sep_cnt_r <= sep_cnt_nxt;
      ft_r      <= ft_nxt;
      len_r     <= len_nxt;
      fld_r     <= fld_nxt;
      sep_r     <= sep_nxt;
      mism_r    <= mism_nxt;
      num_r     <= num_nxt;
      ne_r      <= ne_nxt;
      val_r     <= val_nxt;
      err_r     <= err_nxt;
      if (cls_we) begin
        cls_r[fi] <= dc_cls;
      end
    end
  end

  // template tables, valid only where written
  always_ff @(posedge clk) begin
    if (sep_we) begin
      sep_list_r[sep_cnt_r[SIDX_W-1:0]] <= c;
    end
    if (tpl_we) begin
      ref_len_r[ft_r[IDX_W-1:0]] <= len_r;
    end
    if (lv_we) begin
      last_val_r[lv_idx] <= val_r;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_FIELDS; i++) begin
      snap.classes[2*i +: 2] = cls_r[i];
    end
    snap.total = ft_r;
    snap.error = err_r;
  end

endmodule
`default_nettype wire

[rtl/core/idfc_report.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// idfc_report - report sequencer
// Holds a snapshot of the field classes; one beat per field, or one if none.
// ----------------------------------------------------------------------------
module idfc_report (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire idfc_pkg::rpt_snap_t  snap,
  output logic                      busy,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output idfc_pkg::out_beat_t       out_data
);
  import idfc_pkg::*;

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  rpt_snap_t        snap_r;
  logic             is_last;
  logic             fire;

  assign is_last = (snap_r.total == '0) || (FLD_W'(idx_r) + 1'b1 == snap_r.total);
  assign fire    = busy_r && !out_stall;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (fire) begin
      if (is_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      snap_r <= snap;
    end
  end

  assign busy      = busy_r;
  assign out_valid = busy_r;

  always_comb begin
    out_data.field_index = 4'(idx_r);
    out_data.field_class = (snap_r.total == '0) ? CLS_SAME : snap_r.classes[2*idx_r +: 2];
    out_data.field_count = 5'(snap_r.total);
    out_data.last        = is_last;
    out_data.error       = snap_r.error;
  end

endmodule
`default_nettype wire

[rtl/core/id_field_type_classifier.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// id_field_type_classifier - identifier field type classifier
// Learns a template from the first identifier line, then classes each field
// of later lines as identical, non-decreasing numeric or irregular.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one beat per byte,
//   end-of-line or report command. Bytes and end-of-line give no result and
//   never stall; a new beat is taken every cycle unless a report beat stalls.
//   A report beat snapshots the field classes and error flag; the result
//   channel (out_valid / out_stall / out_data) then gives one beat per
//   template field (one beat with field_count 0 if there is none), the first
//   the cycle after the report is accepted, then one per unstalled cycle.
//   While a report is being sent, byte and end-of-line beats keep flowing;
//   only a second report beat is stalled, and it is taken the cycle after
//   the last result beat leaves.
//   A stalled result beat holds its value.
//   Reset (rst_n low, synchronous) clears classes, counters and the error
//   flag; the next line is taken as a new template. Template tables hold no
//   reset and are read only where written.
//   Data-line compares use a 512x8 reference RAM whose read address is taken
//   from the next cursor, so there is no read bubble.
// ----------------------------------------------------------------------------
module id_field_type_classifier (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire idfc_pkg::in_beat_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output idfc_pkg::out_beat_t       out_data
);
  import idfc_pkg::*;

  logic      in_acc;
  logic      rpt_busy;
  logic      rpt_start;
  rpt_snap_t snap;

  // only a report beat waits for the sequencer
  assign in_stall  = rpt_busy && (in_data.opcode == OP_REPORT);
  assign in_acc    = in_valid && !in_stall;
  assign rpt_start = in_acc && (in_data.opcode == OP_REPORT);

  idfc_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (in_acc),
    .beat  (in_data),
    .snap  (snap)
  );

  idfc_report u_report (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rpt_start),
    .snap      (snap),
    .busy      (rpt_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
